// ===== rtl/pqd_pkg.sv =====
// Shared types and constants for the PCM quantize, downmix and decimate block.
package pqd_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 2'd3;

    // Register widths and reset values.
    localparam int SOURCE_RATE_W = 16;
    localparam int TARGET_RATE_W = 15;
    localparam logic [SOURCE_RATE_W-1:0] SOURCE_RATE_RST = 16'd44100;
    localparam logic [TARGET_RATE_W-1:0] TARGET_RATE_RST = 15'd15625;

    // Output modes.
    localparam logic MODE_FULL     = 1'b0;
    localparam logic MODE_RESAMPLE = 1'b1;

    // Rate accumulator.
    localparam int ACC_W = 17;
    localparam logic [ACC_W-1:0] ACC_MAX = 17'd131071;

    // Input beat: one sample per channel.
    typedef struct packed {
        logic signed [31:0] left_sample;
        logic signed [31:0] right_sample;
    } t_in_beat;

    // Output beat: one quantized sample.
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               last;
    } t_out_beat;

    // What the back end does with a queued item.
    typedef enum logic [1:0] {
        KIND_ONE,   // emit a alone
        KIND_PAIR,  // emit a, then b
        KIND_MIX    // emit (a + b) / 32, truncated toward zero
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] a;
        logic signed [15:0] b;
    } t_task;

endpackage

// ===== rtl/pqd_front.sv =====
// Front end: configuration registers, input acceptance, quantization and decimation.
module pqd_front
    import pqd_pkg::*;
#(
    parameter int FRACTION_BITS = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_beat              i_data,
    input  logic                  i_full,
    output logic                  o_push,
    output t_task                 o_task
);

    // Round at the target precision, clip to [-1, 1) and keep the top bits.
    function automatic logic signed [15:0] quant(input logic signed [31:0] x,
                                                 input int unsigned bits);
        logic signed [33:0] s;
        logic signed [33:0] one;
        logic signed [33:0] res;
        one = 34'sd1 <<< FRACTION_BITS;
        s   = 34'(x) + (34'sd1 <<< (FRACTION_BITS - bits));
        if (s >= one) begin
            s = one - 34'sd1;
        end
        if (s < -one) begin
            s = -one;
        end
        res = s >>> (FRACTION_BITS + 1 - bits);
        return res[15:0];
    endfunction

    logic [SOURCE_RATE_W-1:0] r_source_rate;
    logic [TARGET_RATE_W-1:0] r_target_rate;
    logic                     r_stereo;
    logic                     r_output_mode;
    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         n_acc;

    logic signed [15:0] q16_l;
    logic signed [15:0] q16_r;
    logic signed [15:0] q12_l;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_sat;
    logic               hit;
    logic               accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_rate <= SOURCE_RATE_RST;
            r_target_rate <= TARGET_RATE_RST;
            r_stereo      <= 1'b1;
            r_output_mode <= MODE_FULL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SOURCE_RATE: r_source_rate <= i_cfg_data[SOURCE_RATE_W-1:0];
                REG_TARGET_RATE: r_target_rate <= i_cfg_data[TARGET_RATE_W-1:0];
                REG_STEREO:      r_stereo      <= i_cfg_data[0];
                REG_OUTPUT_MODE: r_output_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Quantizers and the saturating rate accumulator.
    always_comb begin
        q16_l   = quant(i_data.left_sample, 16);
        q16_r   = quant(i_data.right_sample, 16);
        q12_l   = quant(i_data.left_sample, 12);
        acc_sum = {1'b0, r_acc} + (ACC_W + 1)'(r_target_rate);
        acc_sat = (acc_sum > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
        hit     = acc_sat >= ACC_W'(r_source_rate);
        n_acc   = hit ? (acc_sat - ACC_W'(r_source_rate)) : acc_sat;
    end

    // Classify the beat and hand it to the queue.
    always_comb begin
        o_ready = !i_full;
        accept  = i_valid && o_ready;
        o_task  = '{kind: KIND_ONE, a: q16_l, b: q16_r};
        o_push  = 1'b0;
        if (r_output_mode == MODE_FULL) begin
            o_push      = accept;
            o_task.kind = r_stereo ? KIND_PAIR : KIND_ONE;
        end else begin
            o_push = accept && hit;
            if (r_stereo) begin
                o_task.kind = KIND_MIX;
            end else begin
                o_task.a = q12_l;
            end
        end
    end

    // The accumulator advances only on beats taken in resample mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (accept && (r_output_mode == MODE_RESAMPLE)) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ===== rtl/pqd_fifo.sv =====
// Two-entry queue between the front end and the back end.
module pqd_fifo
    import pqd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_task o_task
);

    t_task       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_task  = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/pqd_back.sv =====
// Back end: expands queued items into output beats through an output register.
module pqd_back
    import pqd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_task     i_task,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    logic               r_valid;
    logic               n_valid;
    logic               r_phase;
    logic               n_phase;
    logic signed [15:0] r_sample;
    logic signed [15:0] n_sample;
    logic               r_last;
    logic               n_last;
    logic               out_free;
    logic signed [16:0] mix_sum;
    logic signed [16:0] mix_adj;
    logic signed [16:0] mix_val;

    // Downmix: sum, then divide by 32 truncating toward zero.
    always_comb begin
        mix_sum = 17'(i_task.a) + 17'(i_task.b);
        mix_adj = (mix_sum < 0) ? (mix_sum + 17'sd31) : mix_sum;
        mix_val = mix_adj >>> 5;
    end

    // Load the output register whenever it is empty or being drained.
    always_comb begin
        out_free = !r_valid || i_ready;
        n_valid  = r_valid;
        n_phase  = r_phase;
        n_sample = r_sample;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (out_free) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                case (i_task.kind)
                    KIND_PAIR: begin
                        if (!r_phase) begin
                            n_sample = i_task.a;
                            n_last   = 1'b0;
                            n_phase  = 1'b1;
                        end else begin
                            n_sample = i_task.b;
                            n_last   = 1'b1;
                            n_phase  = 1'b0;
                            o_pop    = 1'b1;
                        end
                    end
                    KIND_MIX: begin
                        n_sample = mix_val[15:0];
                        n_last   = 1'b1;
                        o_pop    = 1'b1;
                    end
                    default: begin
                        n_sample = i_task.a;
                        n_last   = 1'b1;
                        o_pop    = 1'b1;
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_last   <= n_last;
    end

    assign o_valid           = r_valid;
    assign o_data.sample_out = r_sample;
    assign o_data.last       = r_last;

endmodule

// ===== rtl/pcm_quantize_downmix_decimator.sv =====
// Top level of the PCM quantize, downmix and decimate block.
//
// Input channel (i_valid, o_ready, i_data) takes one beat holding a left and
// a right fixed-point sample. Output channel (o_valid, i_ready, o_data)
// delivers 16-bit samples; the last flag marks the final beat caused by an
// input beat. Configuration is to be written through i_cfg_we, i_cfg_index
// and i_cfg_data while the block is idle; the block does not enforce this.
// The front end quantizes and decimates in the accept cycle and pushes work
// into a two-entry queue; the back end drains it into an output register.
// An accepted beat is written into the queue, and the back end then loads
// the output register from the queue head, which raises o_valid.
// One input beat per cycle is taken when each causes at most one result
// and the receiver does not stall; full stereo mode gives two results per
// beat, so the single output port limits the sustained input rate. Decimated
// beats that cause no result are taken without pushing work into the queue.
// Reset restores the default rates, stereo, full mode and clears the
// accumulator and all queued work. When the receiver stalls, the output
// register holds its beat, the queue fills and o_ready then falls.
module pcm_quantize_downmix_decimator
    import pqd_pkg::*;
#(
    parameter int FRACTION_BITS = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_beat              i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_beat             o_data
);

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_task push_task;
    t_task head_task;

    pqd_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_full      (full),
        .o_push      (push),
        .o_task      (push_task)
    );

    pqd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (push_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_task  (head_task)
    );

    pqd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_task  (head_task),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
